### sv/fatc_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// fatc_pkg
// Types and constants shared by the frame-aged texture cache.
// ----------------------------------------------------------------------------
package fatc_pkg;

    localparam int ENTRIES_DEFAULT = 256;
    localparam logic [3:0] STALE_RESET = 4'd2;
    localparam logic [4:0] AGE_MAX = 5'd31;

    typedef enum logic [1:0] {
        OP_LOOKUP = 2'd0,
        OP_INSERT = 2'd1,
        OP_BEGIN  = 2'd2,
        OP_END    = 2'd3
    } t_op;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CLEAR,
        ST_SCAN,
        ST_WRITE,
        ST_DONE
    } t_state;

    typedef struct packed {
        logic [31:0] number;
        logic [63:0] handle;
        logic [63:0] address;
        logic [31:0] length;
        logic [31:0] width;
        logic [31:0] height;
        logic [2:0]  format;
    } t_key;

    typedef struct packed {
        logic        valid;
        logic        seen;
        logic [4:0]  age;
        t_key        key;
        logic [31:0] texture;
    } t_entry;

endpackage
`default_nettype wire

### sv/fatc_store.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// fatc_store
// Entry memory: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module fatc_store
    import fatc_pkg::*;
#(
    parameter int ENTRIES = ENTRIES_DEFAULT,
    parameter int AW = $clog2(ENTRIES)
) (
    input  wire logic          i_clk,
    input  wire logic          i_we,
    input  wire logic [AW-1:0] i_waddr,
    input  wire t_entry        i_wdata,
    input  wire logic [AW-1:0] i_raddr,
    output t_entry             o_rdata
);

    t_entry r_mem [ENTRIES];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule
`default_nettype wire

### sv/frame_aged_texture_cache.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// frame_aged_texture_cache
// Fully associative key-to-texture table with per-frame age eviction.
//
// channel   dir  handshake                  payload
// command   in   i_start & !o_busy          i_opcode, key fields, i_new_texture
// result    out  o_done (one cycle)         o_hit .. o_freed_count
// config    in   psel&penable&pwrite        stale_limit at address 0
//
// After reset a clearing pass writes every entry to zero with busy high.
// Each command scans the memory one entry per cycle through the single read
// port. An insert that finds no free slot reads entry 0 again and evicts it.
// A lookup hit or a free slot ends the scan early.
// Busy drops in the cycle after o_done; results cannot be stalled.
// ----------------------------------------------------------------------------
module frame_aged_texture_cache
    import fatc_pkg::*;
#(
    parameter int ENTRIES = ENTRIES_DEFAULT
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_start,
    output logic             o_busy,
    input  wire logic [1:0]  i_opcode,
    input  wire logic [31:0] i_image_number,
    input  wire logic [63:0] i_image_tag,
    input  wire logic [63:0] i_pixel_address,
    input  wire logic [31:0] i_pixel_bytes,
    input  wire logic [31:0] i_pixel_width,
    input  wire logic [31:0] i_pixel_height,
    input  wire logic [2:0]  i_pixel_format,
    input  wire logic [31:0] i_new_texture,
    output logic             o_done,
    output logic             o_hit,
    output logic [7:0]       o_slot,
    output logic [31:0]      o_found_texture,
    output logic             o_evicted,
    output logic [31:0]      o_evicted_texture,
    output logic [8:0]       o_freed_count,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [0:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]      prdata,
    output logic             pready
);

    localparam int AW = $clog2(ENTRIES);
    localparam int CW = AW + 1;
    localparam logic [AW-1:0] LAST = AW'(ENTRIES - 1);

    t_state r_state, n_state;
    logic [3:0] r_stale;
    t_op r_op;
    t_key r_key;
    logic [31:0] r_tex;
    logic [AW-1:0] r_raddr, n_raddr;   // address last requested; clear pointer in ST_CLEAR
    logic [AW-1:0] r_cur;              // address whose data is on o_rdata
    logic r_rvalid, n_rvalid;
    logic [CW-1:0] r_freed, n_freed;
    logic r_hit, r_ev;
    logic [AW-1:0] r_slot;
    logic [31:0] r_ftex, r_evtex;
    logic set_res;

    logic we;
    logic [AW-1:0] waddr;
    t_entry wdata, rdata;
    t_entry ins;

    fatc_store #(.ENTRIES(ENTRIES), .AW(AW)) u_store (
        .i_clk(i_clk), .i_we(we), .i_waddr(waddr), .i_wdata(wdata),
        .i_raddr(n_raddr), .o_rdata(rdata)
    );

    assign pready = 1'b1;
    assign prdata = {28'd0, r_stale};
    assign o_busy = (r_state != ST_IDLE);

    always_comb begin
        ins = '0;
        ins.valid = 1'b1;
        ins.seen = 1'b1;
        ins.key = r_key;
        ins.texture = r_tex;
    end

    logic match, last_rd;
    t_entry aged;
    logic free_it;
    always_comb begin
        match = rdata.valid && (rdata.key == r_key);
        last_rd = (r_cur == LAST);
        aged = rdata;
        free_it = 1'b0;
        if (rdata.valid) begin
            if (rdata.seen) begin
                aged.age = '0;
            end else begin
                if (rdata.age < AGE_MAX) begin
                    aged.age = rdata.age + 5'd1;
                end
                if (aged.age > {1'b0, r_stale}) begin
                    free_it = 1'b1;
                end
            end
        end
    end

    logic fin_hit, fin_ev;
    logic [AW-1:0] fin_slot;
    logic [31:0] fin_ftex, fin_evtex;
    always_comb begin
        n_state = r_state;
        n_raddr = r_raddr;
        n_rvalid = 1'b0;
        n_freed = r_freed;
        we = 1'b0;
        waddr = r_cur;
        wdata = rdata;
        fin_hit = 1'b0;
        fin_ev = 1'b0;
        fin_slot = '0;
        fin_ftex = '0;
        fin_evtex = '0;
        set_res = 1'b0;
        unique case (r_state)
            ST_IDLE: begin
                if (i_start) begin
                    n_state = ST_SCAN;
                    n_raddr = '0;
                    n_rvalid = 1'b1;
                    n_freed = '0;
                end
            end
            ST_CLEAR: begin
                we = 1'b1;
                waddr = r_raddr;
                wdata = '0;
                if (r_raddr == LAST) begin
                    n_state = ST_IDLE;
                end else begin
                    n_raddr = r_raddr + AW'(1);
                end
            end
            ST_SCAN: begin
                if (r_rvalid) begin
                    n_rvalid = !last_rd;
                    n_raddr = r_cur + AW'(1);
                    priority case (r_op)
                        OP_LOOKUP: begin
                            if (match) begin
                                we = 1'b1;
                                wdata.seen = 1'b1;
                                wdata.age = '0;
                                fin_hit = 1'b1;
                                fin_slot = r_cur;
                                fin_ftex = rdata.texture;
                                set_res = 1'b1;
                                n_state = ST_DONE;
                            end else if (last_rd) begin
                                set_res = 1'b1;
                                n_state = ST_DONE;
                            end
                        end
                        OP_INSERT: begin
                            if (!rdata.valid) begin
                                we = 1'b1;
                                wdata = ins;
                                fin_slot = r_cur;
                                fin_ftex = r_tex;
                                set_res = 1'b1;
                                n_state = ST_DONE;
                            end else if (last_rd) begin
                                n_raddr = '0;
                                n_rvalid = 1'b1;
                                n_state = ST_WRITE;
                            end
                        end
                        OP_BEGIN: begin
                            we = 1'b1;
                            wdata.seen = 1'b0;
                            if (last_rd) begin
                                set_res = 1'b1;
                                n_state = ST_DONE;
                            end
                        end
                        default: begin
                            we = 1'b1;
                            wdata = free_it ? '0 : aged;
                            n_freed = r_freed + CW'(free_it);
                            if (last_rd) begin
                                set_res = 1'b1;
                                n_state = ST_DONE;
                            end
                        end
                    endcase
                end
            end
            ST_WRITE: begin
                if (r_rvalid) begin
                    we = 1'b1;
                    wdata = ins;
                    fin_ev = 1'b1;
                    fin_evtex = rdata.texture;
                    fin_ftex = r_tex;
                    set_res = 1'b1;
                    n_state = ST_DONE;
                end
            end
            ST_DONE: n_state = ST_IDLE;
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_CLEAR;
            r_raddr <= '0;
            r_rvalid <= 1'b0;
            r_stale <= STALE_RESET;
            o_done <= 1'b0;
        end else begin
            r_state <= n_state;
            r_raddr <= n_raddr;
            r_rvalid <= n_rvalid;
            o_done <= set_res;
            if (psel && penable && pwrite && paddr == 1'b0) begin
                r_stale <= pwdata[3:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_cur <= n_raddr;
        r_freed <= n_freed;
        if (r_state == ST_IDLE && i_start) begin
            r_op <= t_op'(i_opcode);
            r_key <= '{i_image_number, i_image_tag, i_pixel_address, i_pixel_bytes,
                       i_pixel_width, i_pixel_height, i_pixel_format};
            r_tex <= i_new_texture;
        end
        if (set_res) begin
            r_hit <= fin_hit;
            r_slot <= fin_slot;
            r_ftex <= fin_ftex;
            r_ev <= fin_ev;
            r_evtex <= fin_evtex;
        end
    end

    always_comb begin
        o_hit = r_hit & o_done;
        o_slot = o_done ? 8'(r_slot) : 8'd0;
        o_found_texture = o_done ? r_ftex : 32'd0;
        o_evicted = r_ev & o_done;
        o_evicted_texture = o_done ? r_evtex : 32'd0;
        o_freed_count = (o_done && r_op == OP_END) ? 9'(r_freed) : 9'd0;
    end

    a_done_pulse: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |=> !o_done) else $error("done held");
    a_done_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> (o_busy && r_state == ST_DONE)) else $error("done outside done state");
    a_ev_insert: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_evicted |-> (r_op == OP_INSERT && o_slot == 8'd0)) else $error("bad evict");

endmodule
`default_nettype wire

### verif/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the frame-aged texture cache. A queue of commands
// (directed corner cases, then random phases under several stale limits)
// feeds a clocked driver; a behavioural copy of the table predicts every
// result, and a clocked monitor compares each o_done transaction with it.
// ----------------------------------------------------------------------------
module tb;
    import fatc_pkg::*;

    localparam int N_ENTRIES = 256;
    localparam int IDLE_LIMIT = 3000;
    localparam int KEY_BITS = $bits(t_key);
    localparam logic [0:0] ADDR_STALE_LIMIT = 1'b0;

    typedef struct {
        t_op         op;
        t_key        key;
        logic [31:0] texture;
    } t_cmd;

    typedef struct {
        logic        hit;
        logic [7:0]  slot;
        logic [31:0] found_texture;
        logic        evicted;
        logic [31:0] evicted_texture;
        logic [8:0]  freed_count;
    } t_res;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_start = 1'b0;
    logic        o_busy;
    logic [1:0]  i_opcode = OP_LOOKUP;
    logic [31:0] i_image_number = '0;
    logic [63:0] i_image_tag = '0;
    logic [63:0] i_pixel_address = '0;
    logic [31:0] i_pixel_bytes = '0;
    logic [31:0] i_pixel_width = '0;
    logic [31:0] i_pixel_height = '0;
    logic [2:0]  i_pixel_format = '0;
    logic [31:0] i_new_texture = '0;
    logic        o_done;
    logic        o_hit;
    logic [7:0]  o_slot;
    logic [31:0] o_found_texture;
    logic        o_evicted;
    logic [31:0] o_evicted_texture;
    logic [8:0]  o_freed_count;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [0:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;

    frame_aged_texture_cache DUT (.*);

    // shadow table
    logic        tbl_valid [N_ENTRIES];
    logic        tbl_seen [N_ENTRIES];
    logic [4:0]  tbl_age [N_ENTRIES];
    t_key        tbl_key [N_ENTRIES];
    logic [31:0] tbl_tex [N_ENTRIES];
    logic [3:0]  stale_limit = STALE_RESET;

    t_cmd pending_cmds[$];
    t_res expected_results[$];
    t_key key_pool[$];
    t_cmd cur_cmd;
    int   gap_left = 0;
    int   gap_mode = 1;
    int   mismatches = 0;
    int   idle_cycles = 0;
    logic apb_written = 1'b0;

    initial begin
        forever #1 i_clk = ~i_clk;
    end

    function automatic void clear_slot(int e);
        tbl_valid[e] = 1'b0;
        tbl_seen[e] = 1'b0;
        tbl_age[e] = '0;
        tbl_key[e] = '0;
        tbl_tex[e] = '0;
    endfunction

    function automatic void cache_predict(t_cmd c);
        t_res r;
        int tgt;
        r = '{default: '0};
        tgt = -1;
        case (c.op)
            OP_LOOKUP: begin
                for (int e = 0; e < N_ENTRIES; e++) begin
                    if (tbl_valid[e] && tbl_key[e] == c.key) begin
                        tbl_seen[e] = 1'b1;
                        tbl_age[e] = '0;
                        r.hit = 1'b1;
                        r.slot = e[7:0];
                        r.found_texture = tbl_tex[e];
                        break;
                    end
                end
            end
            OP_INSERT: begin
                for (int e = 0; e < N_ENTRIES; e++) begin
                    if (!tbl_valid[e]) begin
                        tgt = e;
                        break;
                    end
                end
                if (tgt < 0) begin
                    tgt = 0;
                    r.evicted = 1'b1;
                    r.evicted_texture = tbl_tex[0];
                end
                tbl_valid[tgt] = 1'b1;
                tbl_seen[tgt] = 1'b1;
                tbl_age[tgt] = '0;
                tbl_key[tgt] = c.key;
                tbl_tex[tgt] = c.texture;
                r.slot = tgt[7:0];
                r.found_texture = c.texture;
            end
            OP_BEGIN: begin
                for (int e = 0; e < N_ENTRIES; e++) tbl_seen[e] = 1'b0;
            end
            default: begin
                for (int e = 0; e < N_ENTRIES; e++) begin
                    if (tbl_valid[e]) begin
                        if (tbl_seen[e]) begin
                            tbl_age[e] = '0;
                        end else begin
                            if (tbl_age[e] < AGE_MAX) tbl_age[e] = tbl_age[e] + 5'd1;
                            if (tbl_age[e] > {1'b0, stale_limit}) begin
                                clear_slot(e);
                                r.freed_count = r.freed_count + 9'd1;
                            end
                        end
                    end
                end
            end
        endcase
        expected_results.push_back(r);
    endfunction

    function automatic t_key random_key();
        t_key k;
        k.number = $urandom;
        k.handle = {$urandom, $urandom};
        k.address = {$urandom, $urandom};
        k.length = $urandom;
        k.width = $urandom;
        k.height = $urandom;
        k.format = $urandom_range(0, 7);
        return k;
    endfunction

    function automatic t_key flip_key_bit(t_key k);
        logic [KEY_BITS-1:0] v;
        v = k;
        v[$urandom_range(0, KEY_BITS - 1)] ^= 1'b1;
        return t_key'(v);
    endfunction

    function automatic void push_cmd(t_op op, t_key k, logic [31:0] tex);
        t_cmd c;
        c.op = op;
        c.key = k;
        c.texture = tex;
        pending_cmds.push_back(c);
        if (op == OP_INSERT) begin
            key_pool.push_back(k);
            if (key_pool.size() > 600) void'(key_pool.pop_front());
        end
    endfunction

    function automatic void push_random(int w_ins, int w_look, int w_begin);
        int p;
        int q;
        t_key k;
        p = $urandom_range(0, 99);
        q = $urandom_range(0, 9);
        if (p < w_ins) begin
            if (q < 2 && key_pool.size() > 0)
                k = key_pool[$urandom_range(0, key_pool.size() - 1)];
            else
                k = random_key();
            push_cmd(OP_INSERT, k, $urandom);
        end else if (p < w_ins + w_look) begin
            if (q < 6 && key_pool.size() > 0)
                k = key_pool[$urandom_range(0, key_pool.size() - 1)];
            else if (q < 8 && key_pool.size() > 0)
                k = flip_key_bit(key_pool[$urandom_range(0, key_pool.size() - 1)]);
            else
                k = random_key();
            push_cmd(OP_LOOKUP, k, $urandom);
        end else if (p < w_ins + w_look + w_begin) begin
            push_cmd(OP_BEGIN, random_key(), $urandom);
        end else begin
            push_cmd(OP_END, random_key(), $urandom);
        end
    endfunction

    function automatic int draw_gap();
        int p;
        p = $urandom_range(0, 99);
        if (gap_mode == 0 || p < 50) return 0;
        if (p < 85) return $urandom_range(1, 3);
        if (p < 98) return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    task automatic drive_next();
        cur_cmd = pending_cmds.pop_front();
        i_start <= 1'b1;
        i_opcode <= cur_cmd.op;
        i_image_number <= cur_cmd.key.number;
        i_image_tag <= cur_cmd.key.handle;
        i_pixel_address <= cur_cmd.key.address;
        i_pixel_bytes <= cur_cmd.key.length;
        i_pixel_width <= cur_cmd.key.width;
        i_pixel_height <= cur_cmd.key.height;
        i_pixel_format <= cur_cmd.key.format;
        i_new_texture <= cur_cmd.texture;
    endtask

    // driver
    always @(posedge i_clk) begin
        if (i_start && !o_busy && i_rst_n) begin
            cache_predict(cur_cmd);
            gap_left = draw_gap();
            if (gap_left == 0 && pending_cmds.size() > 0) drive_next();
            else i_start <= 1'b0;
        end else if (!i_start) begin
            if (gap_left > 0) gap_left = gap_left - 1;
            else if (i_rst_n && pending_cmds.size() > 0) drive_next();
        end
    end

    // monitor
    always @(posedge i_clk) begin
        t_res e;
        if (o_done) begin
            if (expected_results.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) $display("unexpected result transaction");
            end else begin
                e = expected_results.pop_front();
                if (o_hit !== e.hit || o_slot !== e.slot
                        || o_found_texture !== e.found_texture
                        || o_evicted !== e.evicted
                        || o_evicted_texture !== e.evicted_texture
                        || o_freed_count !== e.freed_count) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch: exp hit=%0d slot=%0d tex=%h ev=%0d evtex=%h freed=%0d",
                                 e.hit, e.slot, e.found_texture, e.evicted,
                                 e.evicted_texture, e.freed_count,
                                 "\n          got hit=%0d slot=%0d tex=%h ev=%0d evtex=%h freed=%0d",
                                 o_hit, o_slot, o_found_texture, o_evicted,
                                 o_evicted_texture, o_freed_count);
                end
            end
        end
    end

    // watchdog
    always @(posedge i_clk) begin
        if ((i_start && !o_busy) || o_done || apb_written) idle_cycles <= 0;
        else idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("simulation failed");
            $finish;
        end
    end

    task automatic write_stale_limit(logic [3:0] v);
        @(posedge i_clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= ADDR_STALE_LIMIT;
        pwdata <= {28'd0, v};
        @(posedge i_clk);
        penable <= 1'b1;
        apb_written <= 1'b1;
        @(posedge i_clk);
        stale_limit = v;
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        apb_written <= 1'b0;
    endtask

    task automatic drain();
        wait (pending_cmds.size() == 0 && !i_start && expected_results.size() == 0
              && !o_busy);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic run_phase(logic [3:0] lim, int n, int w_ins, int w_look, int w_begin,
                             int mode);
        write_stale_limit(lim);
        gap_mode = mode;
        for (int i = 0; i < n; i++) push_random(w_ins, w_look, w_begin);
        drain();
    endtask

    initial begin
        t_key kmax;
        t_key kzero;
        t_key k;
        for (int e = 0; e < N_ENTRIES; e++) clear_slot(e);
        kmax = '1;
        kzero = '0;
        kzero.format = 3'd7;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed: miss on empty table, extreme keys, near misses per field,
        // duplicate insert, ageing out under the reset stale limit
        push_cmd(OP_LOOKUP, kmax, '0);
        push_cmd(OP_INSERT, kmax, '1);
        push_cmd(OP_INSERT, kzero, '0);
        push_cmd(OP_LOOKUP, kmax, '0);
        push_cmd(OP_LOOKUP, kzero, '1);
        k = kmax; k.number[31] = 1'b0;  push_cmd(OP_LOOKUP, k, '0);
        k = kmax; k.handle[63] = 1'b0;  push_cmd(OP_LOOKUP, k, '0);
        k = kmax; k.address[0] = 1'b0;  push_cmd(OP_LOOKUP, k, '0);
        k = kmax; k.length[0] = 1'b0;   push_cmd(OP_LOOKUP, k, '0);
        k = kmax; k.width[31] = 1'b0;   push_cmd(OP_LOOKUP, k, '0);
        k = kmax; k.height[0] = 1'b0;   push_cmd(OP_LOOKUP, k, '0);
        k = kmax; k.format = 3'd4;      push_cmd(OP_LOOKUP, k, '0);
        push_cmd(OP_INSERT, kmax, 32'h8000_0001);
        push_cmd(OP_LOOKUP, kmax, '0);
        push_cmd(OP_BEGIN, kzero, '0);
        push_cmd(OP_END, kzero, '0);
        push_cmd(OP_END, kzero, '0);
        push_cmd(OP_END, kzero, '0);
        push_cmd(OP_LOOKUP, kmax, '0);
        push_cmd(OP_END, kmax, '0);
        drain();

        // fill past capacity to force evictions, then churn under other limits
        run_phase(4'd15, 420, 80, 15, 3, 1);
        run_phase(4'd0, 330, 25, 45, 15, 1);
        run_phase(4'd7, 300, 35, 40, 12, 0);
        run_phase(4'd2, 280, 40, 35, 12, 1);

        repeat (300) @(posedge i_clk);
        if (mismatches == 0 && expected_results.size() == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule

### files.f
sv/fatc_pkg.sv
sv/fatc_store.sv
sv/frame_aged_texture_cache.sv
verif/tb.sv
